[rtl/bht_pkg.sv]
package bht_pkg;

   localparam int KEY_W        = 24;
   localparam int TAG_W        = 32;
   localparam int MODE_W       = 2;
   localparam int STATUS_W     = 2;
   localparam int BUCKET_W     = 4;
   localparam int SLOT_W       = 2;
   localparam int SLOTS        = 4;
   localparam int FILL_W       = 3;
   localparam int RES_W        = 5;
   localparam int KEY_DIGITS   = KEY_W / 4;

   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

   localparam logic [RES_W-1:0] HASH_MODULUS = 5'd17;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } entry_type;

   typedef struct packed {
      logic                done;
      logic [BUCKET_W-1:0] bucket;
   } hash_rsp_type;

   typedef enum logic [1:0] {
      HASH_IDLE,
      HASH_DIGIT,
      HASH_FOLD
   } hash_state_type;

   typedef enum logic [3:0] {
      SEQ_IDLE,
      SEQ_HASH,
      SEQ_DISPATCH,
      SEQ_INS_RD,
      SEQ_INS_CMP,
      SEQ_INS_PUT,
      SEQ_SRC_RD,
      SEQ_SRC_CMP,
      SEQ_DEL_RD,
      SEQ_DEL_MV,
      SEQ_DONE
   } seq_state_type;

   // Residue r maps to (13 * r) mod 17.
   function automatic logic [RES_W-1:0] mul13_mod17(input logic [RES_W-1:0] r);
      logic [RES_W-1:0] v;
      case (r)
         5'd0:    v = 5'd0;
         5'd1:    v = 5'd13;
         5'd2:    v = 5'd9;
         5'd3:    v = 5'd5;
         5'd4:    v = 5'd1;
         5'd5:    v = 5'd14;
         5'd6:    v = 5'd10;
         5'd7:    v = 5'd6;
         5'd8:    v = 5'd2;
         5'd9:    v = 5'd15;
         5'd10:   v = 5'd11;
         5'd11:   v = 5'd7;
         5'd12:   v = 5'd3;
         5'd13:   v = 5'd16;
         5'd14:   v = 5'd12;
         5'd15:   v = 5'd8;
         5'd16:   v = 5'd4;
         default: v = 5'd0;
      endcase
      return v;
   endfunction

endpackage

[rtl/bht_req_if.sv]
interface bht_req_if
   import bht_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [KEY_W-1:0]  key;
   logic [TAG_W-1:0]  record_tag;

   modport source (output valid, output mode, output key, output record_tag, input ready);
   modport sink   (input valid, input mode, input key, input record_tag, output ready);
endinterface

[rtl/bht_rsp_if.sv]
interface bht_rsp_if
   import bht_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [TAG_W-1:0]    found_tag;
   logic [BUCKET_W-1:0] bucket_index;
   logic [SLOT_W-1:0]   slot_index;

   modport source (output valid, output status, output found_tag, output bucket_index,
                   output slot_index, input ready);
   modport sink   (input valid, input status, input found_tag, input bucket_index,
                   input slot_index, output ready);
endinterface

[rtl/bht_hash.sv]
// Digit-serial bucket hash: residue mod 17 one hex digit per cycle, most
// significant first, then a multiply-by-13 table and a fold into the bucket range.
module bht_hash
   import bht_pkg::*;
#(
   parameter int NUM_BUCKETS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [KEY_W-1:0] key,
   output hash_rsp_type     result
);

   localparam logic [RES_W-1:0] NB = RES_W'(NUM_BUCKETS);

   hash_state_type   state_ff, state_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [2:0]       cnt_ff, cnt_in;
   logic [RES_W-1:0] acc_ff, acc_in;
   logic [RES_W-1:0] h_ff, h_in;
   logic [3:0]       digit;
   logic [5:0]       diff;
   logic [RES_W-1:0] acc_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= HASH_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      h_ff   <= h_in;
   end

   // Since 16 = -1 mod 17, appending a digit d to residue a gives d - a mod 17.
   always_comb begin
      digit    = key_ff[KEY_W-1 -: 4];
      diff     = 6'(digit) + 6'(HASH_MODULUS) - 6'(acc_ff);
      acc_step = (diff >= 6'(HASH_MODULUS)) ? RES_W'(diff - 6'(HASH_MODULUS))
                                            : RES_W'(diff);
   end

   always_comb begin
      state_in      = state_ff;
      key_in        = key_ff;
      cnt_in        = cnt_ff;
      acc_in        = acc_ff;
      h_in          = h_ff;
      result.done   = 1'b0;
      result.bucket = h_ff[BUCKET_W-1:0];
      case (state_ff)
         HASH_IDLE: begin
            if (start) begin
               key_in   = key;
               cnt_in   = 3'd0;
               acc_in   = '0;
               state_in = HASH_DIGIT;
            end
         end
         HASH_DIGIT: begin
            acc_in = acc_step;
            key_in = key_ff << 4;
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'(KEY_DIGITS - 1)) begin
               h_in     = mul13_mod17(acc_step);
               state_in = HASH_FOLD;
            end
         end
         HASH_FOLD: begin
            if (h_ff >= NB) begin
               h_in = h_ff - NB;
            end else begin
               result.done = 1'b1;
               state_in    = HASH_IDLE;
            end
         end
         default: begin
            state_in = HASH_IDLE;
         end
      endcase
   end

endmodule

[rtl/bht_store.sv]
// Slot storage: one write port and one read port with registered read data.
module bht_store
   import bht_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output entry_type                rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  entry_type                wr_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/bucketed_hash_table_unit.sv]
// Flow of a request: the key is hashed (a start step, one step per hex digit, then the fold),
// a dispatch step reads the bucket's fill count, the slots are walked with a read step and a
// compare or move step each, an insert adds a put step, and the response register loads last.
// Throughput: one request at a time; ready returns the cycle after the response is loaded.
// Reset (synchronous, active high) empties every bucket; slot contents are left as they are.
module bucketed_hash_table_unit
   import bht_pkg::*;
#(
   parameter int NUM_BUCKETS = 16
) (
   input logic      clock,
   input logic      reset,
   bht_req_if.sink  req_chan,
   bht_rsp_if.source rsp_chan
);

   localparam int BKT_W  = $clog2(NUM_BUCKETS);
   localparam int ADDR_W = BKT_W + SLOT_W;
   localparam int DEPTH  = NUM_BUCKETS * SLOTS;

   // Sequencer state and the request being worked on.
   seq_state_type       state_ff, state_in;
   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [TAG_W-1:0]    tag_ff, tag_in;
   logic [BUCKET_W-1:0] bucket_ff, bucket_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [SLOT_W-1:0]   idx_ff, idx_in;
   logic [SLOT_W-1:0]   pos_ff, pos_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [TAG_W-1:0]    found_ff, found_in;

   // Response register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [TAG_W-1:0]    rsp_found_ff, rsp_found_in;
   logic [BUCKET_W-1:0] rsp_bucket_ff, rsp_bucket_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;

   // Per-bucket fill counts live in flip-flops so that reset empties the table at once.
   logic [FILL_W-1:0]   fill_mem_ff [NUM_BUCKETS];
   logic                fill_we;
   logic [FILL_W-1:0]   fill_wval;

   logic                hash_start;
   hash_rsp_type        hash_rsp;

   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;
   entry_type           rd_data;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   entry_type           wr_data;

   logic [BKT_W-1:0]    bkt;
   logic                req_xfer;
   logic                rsp_xfer;
   logic                last_slot;

   bht_hash #(
      .NUM_BUCKETS (NUM_BUCKETS)
   ) u_hash (
      .clock  (clock),
      .reset  (reset),
      .start  (hash_start),
      .key    (key_ff),
      .result (hash_rsp)
   );

   bht_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign bkt       = bucket_ff[BKT_W-1:0];
   assign req_xfer  = req_chan.valid && req_chan.ready;
   assign rsp_xfer  = rsp_chan.valid && rsp_chan.ready;
   // The slot under the sequencer is the last live one of the bucket.
   assign last_slot = ((FILL_W'(idx_ff) + FILL_W'(1)) == fill_ff);

   assign req_chan.ready        = (state_ff == SEQ_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.found_tag    = rsp_found_ff;
   assign rsp_chan.bucket_index = rsp_bucket_ff;
   assign rsp_chan.slot_index   = rsp_slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int b = 0; b < NUM_BUCKETS; b++) begin
            fill_mem_ff[b] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fill_we) begin
            fill_mem_ff[bkt] <= fill_wval;
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      tag_ff        <= tag_in;
      bucket_ff     <= bucket_in;
      fill_ff       <= fill_in;
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      status_ff     <= status_in;
      found_ff      <= found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_bucket_ff <= rsp_bucket_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   // The sequencer drives the slot comparisons and the memory ports. Insert walks
   // down from the top live slot, moving each larger entry up by one until it meets a key
   // that is less than or equal to the new one. Remove and lookup walk up from slot zero;
   // a remove then pulls the entries above the hit down by one to close the gap.
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      tag_in        = tag_ff;
      bucket_in     = bucket_ff;
      fill_in       = fill_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_bucket_in = rsp_bucket_ff;
      rsp_slot_in   = rsp_slot_ff;
      fill_we       = 1'b0;
      fill_wval     = fill_ff;
      hash_start    = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = {bkt, idx_ff};
      wr_en         = 1'b0;
      wr_addr       = {bkt, idx_ff};
      wr_data       = rd_data;

      if (rsp_xfer) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         SEQ_IDLE: begin
            if (req_xfer) begin
               mode_in   = req_chan.mode;
               key_in    = req_chan.key;
               tag_in    = req_chan.record_tag;
               pos_in    = '0;
               found_in  = '0;
               status_in = STATUS_NOT_FOUND;
               state_in  = SEQ_HASH;
            end
         end
         SEQ_HASH: begin
            hash_start = 1'b1;
            if (hash_rsp.done) begin
               bucket_in = hash_rsp.bucket;
               state_in  = SEQ_DISPATCH;
            end
         end
         SEQ_DISPATCH: begin
            fill_in = fill_mem_ff[bkt];
            if (mode_ff == MODE_INSERT) begin
               if (fill_mem_ff[bkt] == FILL_W'(SLOTS)) begin
                  status_in = STATUS_FULL;
                  state_in  = SEQ_DONE;
               end else if (fill_mem_ff[bkt] == '0) begin
                  pos_in   = '0;
                  state_in = SEQ_INS_PUT;
               end else begin
                  idx_in   = SLOT_W'(fill_mem_ff[bkt] - FILL_W'(1));
                  state_in = SEQ_INS_RD;
               end
            end else if (mode_ff inside {MODE_REMOVE, MODE_LOOKUP}) begin
               if (fill_mem_ff[bkt] == '0) begin
                  status_in = STATUS_EMPTY;
                  state_in  = SEQ_DONE;
               end else begin
                  idx_in   = '0;
                  state_in = SEQ_SRC_RD;
               end
            end else begin
               status_in = STATUS_NOT_FOUND;
               state_in  = SEQ_DONE;
            end
         end
         SEQ_INS_RD: begin
            rd_en    = 1'b1;
            state_in = SEQ_INS_CMP;
         end
         SEQ_INS_CMP: begin
            if (rd_data.key <= key_ff) begin
               pos_in   = idx_ff + SLOT_W'(1);
               state_in = SEQ_INS_PUT;
            end else begin
               wr_en   = 1'b1;
               wr_addr = {bkt, idx_ff + SLOT_W'(1)};
               if (idx_ff == '0) begin
                  pos_in   = '0;
                  state_in = SEQ_INS_PUT;
               end else begin
                  idx_in   = idx_ff - SLOT_W'(1);
                  state_in = SEQ_INS_RD;
               end
            end
         end
         SEQ_INS_PUT: begin
            wr_en       = 1'b1;
            wr_addr     = {bkt, pos_ff};
            wr_data.key = key_ff;
            wr_data.tag = tag_ff;
            fill_we     = 1'b1;
            fill_wval   = fill_ff + FILL_W'(1);
            status_in   = STATUS_DONE;
            state_in    = SEQ_DONE;
         end
         SEQ_SRC_RD: begin
            rd_en    = 1'b1;
            state_in = SEQ_SRC_CMP;
         end
         SEQ_SRC_CMP: begin
            if (rd_data.key == key_ff) begin
               pos_in = idx_ff;
               if (mode_ff == MODE_LOOKUP) begin
                  found_in  = rd_data.tag;
                  status_in = STATUS_DONE;
                  state_in  = SEQ_DONE;
               end else if (last_slot) begin
                  fill_we   = 1'b1;
                  fill_wval = fill_ff - FILL_W'(1);
                  status_in = STATUS_DONE;
                  state_in  = SEQ_DONE;
               end else begin
                  idx_in   = idx_ff + SLOT_W'(1);
                  state_in = SEQ_DEL_RD;
               end
            end else if (last_slot) begin
               status_in = STATUS_NOT_FOUND;
               state_in  = SEQ_DONE;
            end else begin
               idx_in   = idx_ff + SLOT_W'(1);
               state_in = SEQ_SRC_RD;
            end
         end
         SEQ_DEL_RD: begin
            rd_en    = 1'b1;
            state_in = SEQ_DEL_MV;
         end
         SEQ_DEL_MV: begin
            wr_en   = 1'b1;
            wr_addr = {bkt, idx_ff - SLOT_W'(1)};
            if (last_slot) begin
               fill_we   = 1'b1;
               fill_wval = fill_ff - FILL_W'(1);
               status_in = STATUS_DONE;
               state_in  = SEQ_DONE;
            end else begin
               idx_in   = idx_ff + SLOT_W'(1);
               state_in = SEQ_DEL_RD;
            end
         end
         SEQ_DONE: begin
            // The response register is loaded once the previous result has been taken.
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_found_in  = found_ff;
               rsp_bucket_in = bucket_ff;
               rsp_slot_in   = pos_ff;
               state_in      = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

// Self-checking bench for the bucketed hash table. Requests go in over the
// req_chan interface and responses come back over rsp_chan. A small shadow
// table inside the scoreboard class tracks every bucket, so each accepted
// request yields the response the block must return, in order.
module tb;
   import bht_pkg::*;

   localparam int NUM_BUCKETS  = 16;
   localparam int RANDOM_ITEMS = 800;
   // The limit leaves a wide margin over the worst case per request: the block's
   // own time plus the random idle gaps on each side.
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 40;
   localparam int POOL_DEPTH   = 24;

   // The fourth mode code has no name in the package; the block answers it
   // with "not found" and leaves the table alone.
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [TAG_W-1:0]    found_tag;
      logic [BUCKET_W-1:0] bucket;
      logic [SLOT_W-1:0]   slot;
   } rsp_item_type;

   // Shadow copy of the table plus the queue of responses still owed.
   class bht_scoreboard_type;
      int               errors;
      rsp_item_type     pending_rsp[$];
      logic [KEY_W-1:0] slot_key [NUM_BUCKETS][SLOTS];
      logic [TAG_W-1:0] slot_tag [NUM_BUCKETS][SLOTS];
      int               fill [NUM_BUCKETS];

      function new();
         errors = 0;
         foreach (fill[b]) fill[b] = 0;
      endfunction

      function void report(string what);
         $display("[%0t] mismatch: %s", $time, what);
         errors++;
      endfunction

      function logic [BUCKET_W-1:0] bucket_of(logic [KEY_W-1:0] key);
         logic [31:0] product;
         logic [31:0] residue;
         product = 32'(key) * 32'd13;
         residue = (product % 32'd17) % NUM_BUCKETS;
         return residue[BUCKET_W-1:0];
      endfunction

      // Apply one accepted request to the shadow table and queue its response.
      function void note_request(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                                 logic [TAG_W-1:0] tag);
         rsp_item_type predicted;
         int        bkt;
         int        pos;
         int        i;
         bit        hit;
         bkt = bucket_of(key);
         predicted.status    = STATUS_NOT_FOUND;
         predicted.found_tag = '0;
         predicted.bucket    = BUCKET_W'(bkt);
         predicted.slot      = '0;
         case (mode)
            MODE_INSERT: begin
               if (fill[bkt] >= SLOTS) begin
                  predicted.status = STATUS_FULL;
               end else begin
                  // Equal keys stay ahead of the new entry.
                  pos = 0;
                  while (pos < fill[bkt] && slot_key[bkt][pos] <= key) pos++;
                  for (i = fill[bkt]; i > pos; i--) begin
                     slot_key[bkt][i] = slot_key[bkt][i-1];
                     slot_tag[bkt][i] = slot_tag[bkt][i-1];
                  end
                  slot_key[bkt][pos] = key;
                  slot_tag[bkt][pos] = tag;
                  fill[bkt]++;
                  predicted.status = STATUS_DONE;
                  predicted.slot   = SLOT_W'(pos);
               end
            end
            MODE_REMOVE, MODE_LOOKUP: begin
               if (fill[bkt] == 0) begin
                  predicted.status = STATUS_EMPTY;
               end else begin
                  hit = 1'b0;
                  pos = 0;
                  for (i = 0; i < fill[bkt]; i++) begin
                     if (!hit && slot_key[bkt][i] == key) begin
                        hit = 1'b1;
                        pos = i;
                     end
                  end
                  if (hit) begin
                     predicted.status = STATUS_DONE;
                     predicted.slot   = SLOT_W'(pos);
                     if (mode == MODE_LOOKUP) begin
                        predicted.found_tag = slot_tag[bkt][pos];
                     end else begin
                        for (i = pos; i + 1 < fill[bkt]; i++) begin
                           slot_key[bkt][i] = slot_key[bkt][i+1];
                           slot_tag[bkt][i] = slot_tag[bkt][i+1];
                        end
                        fill[bkt]--;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
         pending_rsp.push_back(predicted);
      endfunction

      function void check_response(logic [STATUS_W-1:0] status, logic [TAG_W-1:0] found_tag,
                                   logic [BUCKET_W-1:0] bucket, logic [SLOT_W-1:0] slot);
         rsp_item_type predicted;
         if (pending_rsp.size() == 0) begin
            report("response transfer with no request outstanding");
            return;
         end
         predicted = pending_rsp.pop_front();
         if (status !== predicted.status)
            report($sformatf("status %0d, expected %0d", status, predicted.status));
         if (found_tag !== predicted.found_tag)
            report($sformatf("found_tag %h, expected %h", found_tag, predicted.found_tag));
         if (bucket !== predicted.bucket)
            report($sformatf("bucket_index %0d, expected %0d", bucket, predicted.bucket));
         if (slot !== predicted.slot)
            report($sformatf("slot_index %0d, expected %0d", slot, predicted.slot));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   bht_req_if req_chan ();
   bht_rsp_if rsp_chan ();

   bucketed_hash_table_unit #(
      .NUM_BUCKETS (NUM_BUCKETS)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   bht_scoreboard_type sb;
   int               cycle_count = 0;
   int               sent_count = 0;
   int               rsp_count = 0;
   // When a calm flag is set that side runs back to back with no idle cycles.
   bit               req_calm = 1'b0;
   bit               rsp_calm = 1'b0;
   // Recently used keys, so that later requests hit the same buckets again.
   logic [KEY_W-1:0] key_pool[$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Response monitor. Values read here are the ones present at the edge,
   // since the block and the bench both update with nonblocking assignments.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         sb.check_response(rsp_chan.status, rsp_chan.found_tag, rsp_chan.bucket_index,
                           rsp_chan.slot_index);
      end
   end

   // Response side: before each transfer the sink holds ready low for a random
   // number of cycles, except during calm stretches.
   initial begin : rsp_sink
      int stall;
      rsp_chan.ready = 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = rsp_calm ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (rsp_chan.valid !== 1'b1);
         rsp_count++;
         if (rsp_count % 64 == 0) rsp_calm = ($urandom_range(0, 3) == 0);
      end
   end

   // Present one request and hold it until the block takes the transfer.
   // Valid stays high across back-to-back requests rather than dropping.
   task automatic send_request(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                               logic [TAG_W-1:0] tag);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.mode       <= mode;
      req_chan.key        <= key;
      req_chan.record_tag <= tag;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      sb.note_request(mode, key, tag);
      sent_count++;
      if (sent_count % 64 == 0) req_calm = ($urandom_range(0, 3) == 0);
   endtask

   // Keys 0, 13, 17 and 34 all land in bucket 0 (13 is the key whose
   // product residue is 16, which folds onto bucket 0). The sequence walks
   // empty, sorted insert with shifting, duplicates, full, first-match
   // lookup, absent keys, gap closing on remove, and the unused mode.
   task automatic run_directed();
      send_request(MODE_LOOKUP, 24'd0, 32'd0);
      send_request(MODE_REMOVE, 24'd13, 32'hFFFF_FFFF);
      send_request(MODE_INSERT, 24'd34, 32'hFFFF_FFFF);
      send_request(MODE_INSERT, 24'd13, 32'h0000_0000);
      send_request(MODE_INSERT, 24'd34, 32'h1234_5678);
      send_request(MODE_INSERT, 24'd0, 32'h8000_0001);
      send_request(MODE_INSERT, 24'd17, 32'hDEAD_BEEF);
      send_request(MODE_LOOKUP, 24'd34, 32'd0);
      send_request(MODE_LOOKUP, 24'd17, 32'd0);
      send_request(MODE_REMOVE, 24'd13, 32'd0);
      send_request(MODE_LOOKUP, 24'd34, 32'd0);
      send_request(MODE_INSERT, 24'd17, 32'h7FFF_FFFE);
      send_request(MODE_REMOVE, 24'd34, 32'd0);
      send_request(MODE_REMOVE, 24'd34, 32'd0);
      send_request(MODE_REMOVE, 24'd34, 32'd0);
      send_request(MODE_UNUSED, 24'hFF_FFFF, 32'hFFFF_FFFF);
      send_request(MODE_INSERT, 24'hFF_FFFF, 32'hA5A5_5A5A);
      send_request(MODE_LOOKUP, 24'hFF_FFFF, 32'd0);
      send_request(MODE_REMOVE, 24'hFF_FFFF, 32'd0);
      send_request(MODE_LOOKUP, 24'd0, 32'd0);
      send_request(MODE_REMOVE, 24'd0, 32'd0);
      send_request(MODE_REMOVE, 24'd17, 32'd0);
      send_request(MODE_LOOKUP, 24'd17, 32'd0);
   endtask

   // Key choice: a fresh key (full range or small), a key seen recently, or
   // a neighbor a multiple of 17 away, which falls in the same bucket.
   function automatic logic [KEY_W-1:0] choose_key();
      logic [KEY_W-1:0] key;
      int               pick;
      pick = $urandom_range(0, 99);
      if (key_pool.size() == 0 || pick < 25) begin
         key = $urandom_range(0, 1) ? KEY_W'($urandom) : KEY_W'($urandom_range(0, 400));
      end else if (pick < 65) begin
         return key_pool[$urandom_range(0, key_pool.size() - 1)];
      end else begin
         key = key_pool[$urandom_range(0, key_pool.size() - 1)];
         if ($urandom_range(0, 1) && key >= 24'd51)
            key = key - KEY_W'(17 * $urandom_range(1, 3));
         else
            key = key + KEY_W'(17 * $urandom_range(1, 3));
      end
      key_pool.push_back(key);
      if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
      return key;
   endfunction

   // Random traffic alternates between insert-heavy stretches, which fill
   // buckets up to the full case, and remove-heavy stretches that drain them.
   task automatic run_random();
      int               n;
      int               pick;
      int               insert_share;
      logic [MODE_W-1:0] mode;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         insert_share = ((n / 100) % 2 == 0) ? 60 : 25;
         pick = $urandom_range(0, 99);
         if (pick < 4)
            mode = MODE_UNUSED;
         else if (pick < 4 + insert_share)
            mode = MODE_INSERT;
         else if (pick < 4 + insert_share + (96 - insert_share) / 2)
            mode = MODE_REMOVE;
         else
            mode = MODE_LOOKUP;
         send_request(mode, choose_key(), $urandom);
      end
   endtask

   initial begin
      sb = new();
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.mode       = MODE_INSERT;
      req_chan.key        = '0;
      req_chan.record_tag = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      req_chan.valid <= 1'b0;
      // Every request has a response, so an empty queue means all are back.
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
